@@ design/cfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants for the command frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

   // parser phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_CMD   = 3'd1;
   localparam logic [2:0] PH_COUNT = 3'd2;
   localparam logic [2:0] PH_LENHI = 3'd3;
   localparam logic [2:0] PH_LENLO = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_TAIL  = 3'd6;
   localparam logic [2:0] PH_SKIP  = 3'd7;

   // result event codes
   localparam logic [2:0] EV_HEADER    = 3'd0;
   localparam logic [2:0] EV_LENGTH    = 3'd1;
   localparam logic [2:0] EV_DATA      = 3'd2;
   localparam logic [2:0] EV_FRAME_OK  = 3'd3;
   localparam logic [2:0] EV_BAD_START = 3'd4;
   localparam logic [2:0] EV_TRUNCATED = 3'd5;

   // input modes
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_LOW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_HIGH  = 3'd4;

   // configuration reset values
   localparam logic [31:0] RST_TIMEOUT    = 32'd1000;
   localparam logic [7:0]  RST_START_BYTE = 8'hE0;
   localparam logic [7:0]  RST_END_BYTE   = 8'hEE;
   localparam logic [7:0]  RST_WIDE_LOW   = 8'h40;
   localparam logic [7:0]  RST_WIDE_HIGH  = 8'h4F;

   localparam logic [31:0] TICKS_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] timeout_ticks;
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [7:0]  wide_low;
      logic [7:0]  wide_high;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  command;
      logic [7:0]  param_index;
      logic [15:0] value;
      logic        frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

endpackage

@@ design/cfp_if.sv @@
// ----------------------------------------------------------------------------
// cfp_req_if / cfp_rsp_if
// Valid/ready channels for received items and parser results.
// ----------------------------------------------------------------------------
interface cfp_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface cfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  command;
   logic [7:0]  param_index;
   logic [15:0] value;
   logic        frame_end;

   modport source (output valid, output event_res, output command, output param_index,
                   output value, output frame_end, input ready);
   modport sink   (input valid, input event_res, input command, input param_index,
                   input value, input frame_end, output ready);
endinterface

@@ design/cfp_csr.sv @@
// ----------------------------------------------------------------------------
// cfp_csr
// Configuration register bank, write only.
// ----------------------------------------------------------------------------
module cfp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cfp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output cfp_pkg::cfg_type                 cfg
);

   cfp_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            cfp_pkg::CSR_TIMEOUT:    cfg_in.timeout_ticks = csr_wdata;
            cfp_pkg::CSR_START_BYTE: cfg_in.start_byte    = csr_wdata[7:0];
            cfp_pkg::CSR_END_BYTE:   cfg_in.end_byte      = csr_wdata[7:0];
            cfp_pkg::CSR_WIDE_LOW:   cfg_in.wide_low      = csr_wdata[7:0];
            cfp_pkg::CSR_WIDE_HIGH:  cfg_in.wide_high     = csr_wdata[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= cfp_pkg::RST_TIMEOUT;
         cfg_ff.start_byte    <= cfp_pkg::RST_START_BYTE;
         cfg_ff.end_byte      <= cfp_pkg::RST_END_BYTE;
         cfg_ff.wide_low      <= cfp_pkg::RST_WIDE_LOW;
         cfg_ff.wide_high     <= cfp_pkg::RST_WIDE_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/cfp_parser.sv @@
// ----------------------------------------------------------------------------
// cfp_parser
// Frame parser state and next-state logic; one item per accepted transaction.
// ----------------------------------------------------------------------------
module cfp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic                  mode,
   input  logic [7:0]            rx_byte,
   input  cfp_pkg::cfg_type      cfg,
   output cfp_pkg::result_type   result
);

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  total_ff, total_in;
   logic [7:0]  counter_ff, counter_in;
   logic [7:0]  len_high_ff, len_high_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [31:0] idle_ff, idle_in;

   logic [31:0] ticks_inc;
   logic [15:0] len_word;
   logic [15:0] left_dec;
   logic        is_wide_cur;
   logic        is_last;
   logic        is_end;

   cfp_pkg::result_type res;

   always_comb begin
      ticks_inc   = (idle_ff == cfp_pkg::TICKS_MAX) ? idle_ff : idle_ff + 32'd1;
      len_word    = {len_high_ff, rx_byte};
      left_dec    = bytes_left_ff - 16'd1;
      is_wide_cur = (command_ff >= cfg.wide_low) && (command_ff <= cfg.wide_high);
      is_last     = ({1'b0, counter_ff} + 9'd1) >= {1'b0, total_ff};
      is_end      = (rx_byte == cfg.end_byte);
   end

   always_comb begin
      phase_in      = phase_ff;
      command_in    = command_ff;
      total_in      = total_ff;
      counter_in    = counter_ff;
      len_high_in   = len_high_ff;
      bytes_left_in = bytes_left_ff;
      idle_in       = idle_ff;
      res           = '0;

      if (mode == cfp_pkg::MODE_TICK) begin
         if (phase_ff != cfp_pkg::PH_IDLE) begin
            if (ticks_inc < cfg.timeout_ticks) begin
               idle_in = ticks_inc;
            end else begin
               idle_in  = '0;
               phase_in = cfp_pkg::PH_IDLE;
               if (phase_ff != cfp_pkg::PH_SKIP) begin
                  res.valid               = 1'b1;
                  res.payload.event_res   = cfp_pkg::EV_TRUNCATED;
                  res.payload.command     = command_ff;
                  res.payload.param_index = counter_ff;
                  res.payload.frame_end   = 1'b1;
               end
            end
         end
      end else begin
         idle_in = '0;
         unique case (phase_ff)
            cfp_pkg::PH_IDLE: begin
               if (rx_byte == cfg.start_byte) begin
                  command_in    = '0;
                  total_in      = '0;
                  counter_in    = '0;
                  len_high_in   = '0;
                  bytes_left_in = '0;
                  phase_in      = cfp_pkg::PH_CMD;
               end else begin
                  phase_in              = is_end ? cfp_pkg::PH_IDLE : cfp_pkg::PH_SKIP;
                  res.valid             = 1'b1;
                  res.payload.event_res = cfp_pkg::EV_BAD_START;
                  res.payload.frame_end = 1'b1;
               end
            end
            cfp_pkg::PH_SKIP: begin
               if (is_end) phase_in = cfp_pkg::PH_IDLE;
            end
            cfp_pkg::PH_TAIL: begin
               if (is_end) begin
                  phase_in                = cfp_pkg::PH_IDLE;
                  res.valid               = 1'b1;
                  res.payload.event_res   = cfp_pkg::EV_FRAME_OK;
                  res.payload.command     = command_ff;
                  res.payload.param_index = total_ff;
                  res.payload.frame_end   = 1'b1;
               end
            end
            cfp_pkg::PH_DATA: begin
               bytes_left_in           = left_dec;
               res.valid               = 1'b1;
               res.payload.event_res   = cfp_pkg::EV_DATA;
               res.payload.command     = command_ff;
               res.payload.param_index = counter_ff;
               res.payload.value       = {8'd0, rx_byte};
               if (left_dec == 16'd0) begin
                  if (is_last) begin
                     phase_in = cfp_pkg::PH_TAIL;
                  end else begin
                     counter_in = counter_ff + 8'd1;
                     if (is_wide_cur) begin
                        phase_in = cfp_pkg::PH_LENHI;
                     end else begin
                        len_high_in = '0;
                        phase_in    = cfp_pkg::PH_LENLO;
                     end
                  end
               end
            end
            default: begin
               // header and length bytes: the end byte cuts the frame short
               if (is_end) begin
                  phase_in                = cfp_pkg::PH_IDLE;
                  res.valid               = 1'b1;
                  res.payload.event_res   = cfp_pkg::EV_TRUNCATED;
                  res.payload.command     = command_ff;
                  res.payload.param_index = counter_ff;
                  res.payload.frame_end   = 1'b1;
               end else if (phase_ff == cfp_pkg::PH_CMD) begin
                  command_in = rx_byte;
                  phase_in   = cfp_pkg::PH_COUNT;
               end else if (phase_ff == cfp_pkg::PH_COUNT) begin
                  total_in                = rx_byte;
                  counter_in              = '0;
                  res.valid               = 1'b1;
                  res.payload.event_res   = cfp_pkg::EV_HEADER;
                  res.payload.command     = command_ff;
                  res.payload.param_index = rx_byte;
                  if (rx_byte == 8'd0) begin
                     phase_in = cfp_pkg::PH_TAIL;
                  end else if (is_wide_cur) begin
                     phase_in = cfp_pkg::PH_LENHI;
                  end else begin
                     len_high_in = '0;
                     phase_in    = cfp_pkg::PH_LENLO;
                  end
               end else if (phase_ff == cfp_pkg::PH_LENHI) begin
                  len_high_in = rx_byte;
                  phase_in    = cfp_pkg::PH_LENLO;
               end else begin
                  len_high_in             = '0;
                  bytes_left_in           = len_word;
                  res.valid               = 1'b1;
                  res.payload.event_res   = cfp_pkg::EV_LENGTH;
                  res.payload.command     = command_ff;
                  res.payload.param_index = counter_ff;
                  res.payload.value       = len_word;
                  if (len_word != 16'd0) begin
                     phase_in = cfp_pkg::PH_DATA;
                  end else if (is_last) begin
                     phase_in = cfp_pkg::PH_TAIL;
                  end else begin
                     counter_in = counter_ff + 8'd1;
                     if (is_wide_cur) begin
                        phase_in = cfp_pkg::PH_LENHI;
                     end else begin
                        phase_in = cfp_pkg::PH_LENLO;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= cfp_pkg::PH_IDLE;
         command_ff    <= '0;
         total_ff      <= '0;
         counter_ff    <= '0;
         len_high_ff   <= '0;
         bytes_left_ff <= '0;
         idle_ff       <= '0;
      end else if (take) begin
         phase_ff      <= phase_in;
         command_ff    <= command_in;
         total_ff      <= total_in;
         counter_ff    <= counter_in;
         len_high_ff   <= len_high_in;
         bytes_left_ff <= bytes_left_in;
         idle_ff       <= idle_in;
      end
   end

   always_comb begin
      result       = res;
      result.valid = res.valid & take;
   end

endmodule

@@ design/cfp_out_reg.sv @@
// ----------------------------------------------------------------------------
// cfp_out_reg
// Result register with valid flag; frees itself in the cycle it is taken.
// ----------------------------------------------------------------------------
module cfp_out_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  cfp_pkg::result_type        result,
   input  logic                       out_ready,
   output logic                       out_valid,
   output logic                       can_load,
   output cfp_pkg::rsp_payload_type   out_payload
);

   logic                     valid_ff, valid_in;
   cfp_pkg::rsp_payload_type payload_ff;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      if (result.valid) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         payload_ff <= result.payload;
      end
   end

   assign out_valid   = valid_ff;
   assign out_payload = payload_ff;

endmodule

@@ design/command_frame_parser.sv @@
// ----------------------------------------------------------------------------
// command_frame_parser
// Parses command frames (start, command, count, lengths, data, end) from a
// byte/tick stream and reports header, lengths, data, frame end and errors.
// ----------------------------------------------------------------------------
// A result shows on rsp in the cycle after its request transaction.
// Throughput: one request transaction per cycle when not stalled, set by the single state
//   update between the parser registers and the result register.
// The request side stalls only while a result waits and rsp is not ready.
// Reset (synchronous, active high): parser waits for a start byte, counters
//   clear, configuration returns to its defaults, result register empties.
// ----------------------------------------------------------------------------
module command_frame_parser (
   input  logic                             clock,
   input  logic                             reset,
   cfp_req_if.sink                          req_if,
   cfp_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [cfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cfp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   cfp_pkg::cfg_type          cfg;
   cfp_pkg::result_type       result;
   cfp_pkg::rsp_payload_type  rsp_payload;
   logic                      can_load;
   logic                      take;

   // a request transaction completes whenever the result slot is free
   // or being drained in the same cycle
   assign req_if.ready = can_load;
   assign take         = req_if.valid && can_load;

   cfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state update and result selection, one item per transaction
   cfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .mode    (req_if.mode),
      .rx_byte (req_if.rx_byte),
      .cfg     (cfg),
      .result  (result)
   );

   // result register parts the two sides
   cfp_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .out_ready   (rsp_if.ready),
      .out_valid   (rsp_if.valid),
      .can_load    (can_load),
      .out_payload (rsp_payload)
   );

   assign rsp_if.event_res   = rsp_payload.event_res;
   assign rsp_if.command     = rsp_payload.command;
   assign rsp_if.param_index = rsp_payload.param_index;
   assign rsp_if.value       = rsp_payload.value;
   assign rsp_if.frame_end   = rsp_payload.frame_end;

   // frame_end marks exactly the closing events
   a_frame_end_code : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.frame_end ==
         ((rsp_if.event_res == cfp_pkg::EV_FRAME_OK) ||
          (rsp_if.event_res == cfp_pkg::EV_BAD_START) ||
          (rsp_if.event_res == cfp_pkg::EV_TRUNCATED))))
      else $error("frame_end does not match event code");

   // bad start carries no frame context
   a_bad_start_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.event_res == cfp_pkg::EV_BAD_START)) |->
         ((rsp_if.command == 8'd0) && (rsp_if.param_index == 8'd0) &&
          (rsp_if.value == 16'd0)))
      else $error("bad start result carries frame fields");

   // requests stall only behind a waiting result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready))
      else $error("request stalled without a pending result");

   // a result shown while stalled stays until taken
   a_result_held : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> (rsp_if.valid && $stable(rsp_payload)))
      else $error("pending result dropped or changed");

endmodule
